// ===== design/rpi_pkg.sv =====
package rpi_pkg;

  // Fixed-point format of every field.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_W    = 32;

  // Width of a rounded 32 x 32 product.
  localparam int unsigned MR_W = 2 * WORD_W - FRAC_BITS;

  // Root / divide unit: result width, operand width, remainder width.
  localparam int unsigned RES_W  = WORD_W;
  localparam int unsigned OPND_W = 2 * RES_W;
  localparam int unsigned REM_W  = RES_W + 3;

  localparam int unsigned DEF_SIDE_W = 1;

  localparam logic [15:0] FACING_EPS_RESET = 16'd66;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // Primitive kind codes. The spare code behaves as a plane.
  typedef enum logic [1:0] {
    PRIM_SPHERE = 2'd0,
    PRIM_PLANE  = 2'd1,
    PRIM_DISC   = 2'd2,
    PRIM_SPARE  = 2'd3
  } prim_type_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] ray_origin_x;
    logic signed [31:0] ray_origin_y;
    logic signed [31:0] ray_origin_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
    logic [30:0]        prim_radius;
    logic signed [31:0] prim_normal_x;
    logic signed [31:0] prim_normal_y;
    logic signed [31:0] prim_normal_z;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [31:0] hit_point_z;
    logic signed [31:0] surface_normal_x;
    logic signed [31:0] surface_normal_y;
    logic signed [31:0] surface_normal_z;
  } rsp_t;

  // Exact product, rounded to FRAC_BITS fraction bits with ties toward plus infinity.
  function automatic logic signed [MR_W-1:0] mul_round(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [2*WORD_W-1:0] p;
    logic signed [2*WORD_W-1:0] r;
    p = a * b;
    r = p + ((2*WORD_W)'(1) <<< (FRAC_BITS - 1));
    return r[2*WORD_W-1:FRAC_BITS];
  endfunction

  // Saturate a wide signed value to one word.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] res;
    if (v > 64'(WORD_MAX)) begin
      res = WORD_MAX;
    end else if (v < 64'(WORD_MIN)) begin
      res = WORD_MIN;
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/ray_primitive_intersection_core.sv =====
// Ray / primitive intersection core. Each word on req_i is one local-space ray together
// with a sphere, plane or disc centered at the origin; for every accepted word the core
// returns exactly one result word on rsp_o, marked by a one-cycle result_valid_o strobe,
// in the order the words came in. The core is fully pipelined and takes a new word on
// every clock edge, so busy stays low; the receiver cannot stall the core and must take
// each result in the cycle it is shown. The core holds three 32-stage digit-recurrence
// units in series: the first forms the half-chord square root of a sphere or the plane
// distance quotient, the second the length of the hit point, and the third (three lanes
// side by side) the normalized sphere normal. All arithmetic is signed with 16 fraction
// bits and every word is Q16.16; products round ties upward, quotients round to nearest
// with ties away from zero, and every returned value saturates to 32 bits. The facing
// epsilon register may be written only while no word is in flight.
module ray_primitive_intersection_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rpi_pkg::req_t req_i,
  output logic          result_valid_o,
  output rpi_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);

  localparam int unsigned W   = rpi_pkg::WORD_W;
  localparam int unsigned MW  = rpi_pkg::MR_W;
  localparam int unsigned DW  = MW + 2;
  localparam int unsigned FB  = rpi_pkg::FRAC_BITS;
  localparam int unsigned OW  = rpi_pkg::OPND_W;

  typedef logic [2:0][W-1:0]  vec3_t;
  typedef logic [2:0][MW-1:0] prod3_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         typ;
    logic signed [W-1:0] tcs;
    logic [MW-1:0]      r2;
    vec3_t              o;
    vec3_t              d;
    vec3_t              n;
  } u1_side_t;

  typedef struct packed {
    logic               hit;
    logic               is_sph;
    logic               ll_pos;
    logic signed [W-1:0] t;
    vec3_t              x;
    vec3_t              n;
  } u2_side_t;

  typedef struct packed {
    u2_side_t base;
    logic     neg;
  } u3_side_t;

  // The core has no internal back-pressure.
  assign busy = 1'b0;

  logic [15:0] facing_eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      facing_eps_q <= rpi_pkg::FACING_EPS_RESET;
    end else if (cfg_we_i) begin
      facing_eps_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: all first-level products (origin.dir, origin.origin, normal.dir,
  // origin.normal and radius squared), each rounded to Q32.16.
  // ---------------------------------------------------------------------------
  vec3_t  in_o, in_d, in_n;
  prod3_t s1_pod_d, s1_poo_d, s1_pnd_d, s1_pon_d;

  assign in_o = {req_i.ray_origin_z, req_i.ray_origin_y, req_i.ray_origin_x};
  assign in_d = {req_i.ray_dir_z, req_i.ray_dir_y, req_i.ray_dir_x};
  assign in_n = {req_i.prim_normal_z, req_i.prim_normal_y, req_i.prim_normal_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_pod_d[i] = rpi_pkg::mul_round($signed(in_o[i]), $signed(in_d[i]));
      s1_poo_d[i] = rpi_pkg::mul_round($signed(in_o[i]), $signed(in_o[i]));
      s1_pnd_d[i] = rpi_pkg::mul_round($signed(in_n[i]), $signed(in_d[i]));
      s1_pon_d[i] = rpi_pkg::mul_round($signed(in_o[i]), $signed(in_n[i]));
    end
  end

  logic         s1_vld_q;
  logic [1:0]   s1_typ_q;
  vec3_t        s1_o_q, s1_d_q, s1_n_q;
  prod3_t       s1_pod_q, s1_poo_q, s1_pnd_q, s1_pon_q;
  logic [MW-1:0] s1_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_typ_q <= req_i.req_type;
    s1_o_q   <= in_o;
    s1_d_q   <= in_d;
    s1_n_q   <= in_n;
    s1_pod_q <= s1_pod_d;
    s1_poo_q <= s1_poo_d;
    s1_pnd_q <= s1_pnd_d;
    s1_pon_q <= s1_pon_d;
    s1_r2_q  <= rpi_pkg::mul_round($signed({1'b0, req_i.prim_radius}),
                                   $signed({1'b0, req_i.prim_radius}));
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the dot products. tca and the facing denominator are negated dots.
  // ---------------------------------------------------------------------------
  function automatic logic signed [DW-1:0] sum3(input prod3_t p);
    return DW'($signed(p[0])) + DW'($signed(p[1])) + DW'($signed(p[2]));
  endfunction

  logic                 s2_vld_q;
  logic [1:0]           s2_typ_q;
  vec3_t                s2_o_q, s2_d_q, s2_n_q;
  logic signed [DW-1:0] s2_tca_q, s2_doo_q, s2_den_q, s2_don_q;
  logic [MW-1:0]        s2_r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_typ_q <= s1_typ_q;
    s2_o_q   <= s1_o_q;
    s2_d_q   <= s1_d_q;
    s2_n_q   <= s1_n_q;
    s2_tca_q <= -sum3(s1_pod_q);
    s2_doo_q <= sum3(s1_poo_q);
    s2_den_q <= -sum3(s1_pnd_q);
    s2_don_q <= sum3(s1_pon_q);
    s2_r2_q  <= s1_r2_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sphere tca squared; plane facing test and the rounded quotient setup.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] s3_tcs_d, s3_num_d, s3_den_d;
  logic                s3_pl_ok_d;

  always_comb begin
    s3_tcs_d   = rpi_pkg::sat_word(64'(s2_tca_q));
    s3_num_d   = rpi_pkg::sat_word(64'(s2_don_q));
    s3_den_d   = rpi_pkg::sat_word(64'(s2_den_q));
    s3_pl_ok_d = (s2_den_q > 0) && (s2_den_q >= $signed(DW'(facing_eps_q)))
                 && !s2_don_q[DW-1];
  end

  logic                 s3_vld_q;
  logic [1:0]           s3_typ_q;
  vec3_t                s3_o_q, s3_d_q, s3_n_q;
  logic signed [W-1:0]  s3_tcs_q;
  logic signed [MW-1:0] s3_tsq_q;
  logic                 s3_sph_ok_q, s3_pl_ok_q;
  logic signed [DW-1:0] s3_doo_q;
  logic [MW-1:0]        s3_r2_q;
  logic [OW-1:0]        s3_dvn_q;
  logic [W-1:0]         s3_dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_typ_q    <= s2_typ_q;
    s3_o_q      <= s2_o_q;
    s3_d_q      <= s2_d_q;
    s3_n_q      <= s2_n_q;
    s3_tcs_q    <= s3_tcs_d;
    s3_tsq_q    <= rpi_pkg::mul_round(s3_tcs_d, s3_tcs_d);
    s3_sph_ok_q <= !s2_tca_q[DW-1];
    s3_pl_ok_q  <= s3_pl_ok_d;
    s3_doo_q    <= s2_doo_q;
    s3_r2_q     <= s2_r2_q;
    s3_dvn_q    <= (OW'(unsigned'(s3_num_d)) << FB) + OW'(s3_den_d[W-1:1]);
    s3_dvd_q    <= s3_den_d;
  end

  // ---------------------------------------------------------------------------
  // First root / divide unit: half-chord root for a sphere, distance quotient for a
  // plane or disc. The radicand is r^2 - d^2, which is negative only on a miss.
  // ---------------------------------------------------------------------------
  localparam int unsigned AW = DW + 1;

  logic signed [AW-1:0] d2, a_rad;
  logic                 u1_is_sph;
  u1_side_t             u1_side_in, u1_side_out;
  logic [OW-1:0]        u1_opnd;
  logic                 u1_vld;
  logic [W-1:0]         u1_res;
  logic                 u1_ovf;

  always_comb begin
    d2        = AW'(s3_doo_q) - AW'(s3_tsq_q);
    a_rad     = AW'($signed({1'b0, s3_r2_q})) - d2;
    u1_is_sph = s3_typ_q == rpi_pkg::PRIM_SPHERE;
    u1_opnd   = u1_is_sph ? (OW'(a_rad[MW-1:0]) << FB) : s3_dvn_q;
    u1_side_in.hit = u1_is_sph ? (s3_sph_ok_q && !a_rad[AW-1]) : s3_pl_ok_q;
    u1_side_in.typ = s3_typ_q;
    u1_side_in.tcs = s3_tcs_q;
    u1_side_in.r2  = s3_r2_q;
    u1_side_in.o   = s3_o_q;
    u1_side_in.d   = s3_d_q;
    u1_side_in.n   = s3_n_q;
  end

  logic [$bits(u1_side_t)-1:0] u1_side_bits;

  rpi_root_div #(
    .SIDE_W($bits(u1_side_t))
  ) u_root_div_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s3_vld_q),
    .in_sqrt_i  (u1_is_sph),
    .in_opnd_i  (u1_opnd),
    .in_dvs_i   (s3_dvd_q),
    .in_side_i  (u1_side_in),
    .out_valid_o(u1_vld),
    .out_res_o  (u1_res),
    .out_ovf_o  (u1_ovf),
    .out_side_o (u1_side_bits)
  );

  assign u1_side_out = u1_side_t'(u1_side_bits);

  // ---------------------------------------------------------------------------
  // Stage 5: the ray parameter t.
  // ---------------------------------------------------------------------------
  logic signed [W+1:0] t_diff;
  logic signed [W-1:0] s5_t_d;

  always_comb begin
    t_diff = (W + 2)'(u1_side_out.tcs) - $signed({2'b00, u1_res});
    if (u1_side_out.typ == rpi_pkg::PRIM_SPHERE) begin
      s5_t_d = rpi_pkg::sat_word(64'(t_diff));
    end else if (u1_ovf || u1_res[W-1]) begin
      s5_t_d = rpi_pkg::WORD_MAX;
    end else begin
      s5_t_d = u1_res;
    end
  end

  logic                s5_vld_q;
  u1_side_t            s5_side_q;
  logic signed [W-1:0] s5_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= u1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_side_q <= u1_side_out;
    s5_t_q    <= s5_t_d;
  end

  // ---------------------------------------------------------------------------
  // Stages 6 to 8: hit point o + d*t, then its squared components.
  // ---------------------------------------------------------------------------
  prod3_t              s6_pd_d;
  logic                s6_vld_q;
  u1_side_t            s6_side_q;
  logic signed [W-1:0] s6_t_q;
  prod3_t              s6_pd_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_pd_d[i] = rpi_pkg::mul_round($signed(s5_side_q.d[i]), s5_t_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    s6_t_q    <= s5_t_q;
    s6_pd_q   <= s6_pd_d;
  end

  vec3_t               s7_x_d;
  logic                s7_vld_q;
  u1_side_t            s7_side_q;
  logic signed [W-1:0] s7_t_q;
  vec3_t               s7_x_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s7_x_d[i] = rpi_pkg::sat_word(64'($signed(s6_side_q.o[i])) + 64'($signed(s6_pd_q[i])));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_side_q <= s6_side_q;
    s7_t_q    <= s6_t_q;
    s7_x_q    <= s7_x_d;
  end

  prod3_t              s8_px_d;
  logic                s8_vld_q;
  u1_side_t            s8_side_q;
  logic signed [W-1:0] s8_t_q;
  vec3_t               s8_x_q;
  prod3_t              s8_px_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s8_px_d[i] = rpi_pkg::mul_round($signed(s7_x_q[i]), $signed(s7_x_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s8_side_q <= s7_side_q;
    s8_t_q    <= s7_t_q;
    s8_x_q    <= s7_x_q;
    s8_px_q   <= s8_px_d;
  end

  // ---------------------------------------------------------------------------
  // Second unit: length of the hit point. The squared length also decides whether
  // the hit lies inside a disc.
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] ll;
  u2_side_t             u2_side_in, u2_side_out;
  logic [OW-1:0]        u2_opnd;
  logic                 u2_vld;
  logic [W-1:0]         u2_res;
  logic                 u2_ovf;
  logic [$bits(u2_side_t)-1:0] u2_side_bits;

  always_comb begin
    ll      = sum3(s8_px_q);
    u2_opnd = OW'(ll[MW-1:0]) << FB;
    u2_side_in.hit    = s8_side_q.hit
                        && !((s8_side_q.typ == rpi_pkg::PRIM_DISC)
                             && (ll > $signed(DW'(s8_side_q.r2))));
    u2_side_in.is_sph = s8_side_q.typ == rpi_pkg::PRIM_SPHERE;
    u2_side_in.ll_pos = ll != '0;
    u2_side_in.t      = s8_t_q;
    u2_side_in.x      = s8_x_q;
    u2_side_in.n      = s8_side_q.n;
  end

  rpi_root_div #(
    .SIDE_W($bits(u2_side_t))
  ) u_root_len (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s8_vld_q),
    .in_sqrt_i  (1'b1),
    .in_opnd_i  (u2_opnd),
    .in_dvs_i   ('0),
    .in_side_i  (u2_side_in),
    .out_valid_o(u2_vld),
    .out_res_o  (u2_res),
    .out_ovf_o  (u2_ovf),
    .out_side_o (u2_side_bits)
  );

  assign u2_side_out = u2_side_t'(u2_side_bits);

  // ---------------------------------------------------------------------------
  // Third unit, three lanes: |x_i| * 2^16 / len, rounded to nearest. Each lane
  // carries the sign of its component; lane 0 also carries the rest of the word.
  // ---------------------------------------------------------------------------
  logic [2:0][OW-1:0] nrm_opnd;
  logic [2:0]         nrm_neg_in;
  logic [2:0]         nrm_vld;
  logic [2:0][W-1:0]  nrm_res;
  logic [2:0]         nrm_ovf;
  logic [2:0]         nrm_neg_out;
  u3_side_t           u3_side_in, u3_side_out;
  logic [$bits(u3_side_t)-1:0] u3_side_bits;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_neg_in[i] = u2_side_out.x[i][W-1];
      nrm_opnd[i]   = (OW'(nrm_neg_in[i] ? W'(-$signed(u2_side_out.x[i])) : u2_side_out.x[i])
                       << FB) + OW'(u2_res[W-1:1]);
    end
    u3_side_in.base = u2_side_out;
    u3_side_in.neg  = nrm_neg_in[0];
  end

  rpi_root_div #(
    .SIDE_W($bits(u3_side_t))
  ) u_div_nx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (u2_vld),
    .in_sqrt_i  (u2_ovf),
    .in_opnd_i  (nrm_opnd[0]),
    .in_dvs_i   (u2_res),
    .in_side_i  (u3_side_in),
    .out_valid_o(nrm_vld[0]),
    .out_res_o  (nrm_res[0]),
    .out_ovf_o  (nrm_ovf[0]),
    .out_side_o (u3_side_bits)
  );

  assign u3_side_out    = u3_side_t'(u3_side_bits);
  assign nrm_neg_out[0] = u3_side_out.neg;

  for (genvar g = 1; g < 3; g++) begin : g_nrm_lane
    rpi_root_div #(
      .SIDE_W(1)
    ) u_div_n (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (u2_vld),
      .in_sqrt_i  (u2_ovf),
      .in_opnd_i  (nrm_opnd[g]),
      .in_dvs_i   (u2_res),
      .in_side_i  (nrm_neg_in[g]),
      .out_valid_o(nrm_vld[g]),
      .out_res_o  (nrm_res[g]),
      .out_ovf_o  (nrm_ovf[g]),
      .out_side_o (nrm_neg_out[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: sign and saturate the normal, select per primitive, and clear
  // every field on a miss.
  // ---------------------------------------------------------------------------
  localparam logic [W-1:0] MIN_MAG = {1'b1, {(W - 1){1'b0}}};

  vec3_t         sn_sph;
  rpi_pkg::rsp_t rsp_d;
  u2_side_t      fin;

  always_comb begin
    fin = u3_side_out.base;
    for (int i = 0; i < 3; i++) begin
      if (!nrm_neg_out[i]) begin
        sn_sph[i] = (nrm_ovf[i] || nrm_res[i][W-1]) ? rpi_pkg::WORD_MAX : nrm_res[i];
      end else if (nrm_ovf[i] || (nrm_res[i] > MIN_MAG)) begin
        sn_sph[i] = rpi_pkg::WORD_MIN;
      end else begin
        sn_sph[i] = W'(-$signed(nrm_res[i]));
      end
    end
    rsp_d = '0;
    if (fin.hit) begin
      rsp_d.hit          = 1'b1;
      rsp_d.hit_distance = fin.t;
      rsp_d.hit_point_x  = fin.x[0];
      rsp_d.hit_point_y  = fin.x[1];
      rsp_d.hit_point_z  = fin.x[2];
      if (!fin.is_sph) begin
        rsp_d.surface_normal_x = fin.n[0];
        rsp_d.surface_normal_y = fin.n[1];
        rsp_d.surface_normal_z = fin.n[2];
      end else if (fin.ll_pos) begin
        rsp_d.surface_normal_x = sn_sph[0];
        rsp_d.surface_normal_y = sn_sph[1];
        rsp_d.surface_normal_z = sn_sph[2];
      end
    end
  end

  logic          out_vld_q;
  logic          out_plane_q;
  rpi_pkg::rsp_t out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= nrm_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q   <= rsp_d;
    out_plane_q <= !fin.is_sph;
  end

  assign result_valid_o = out_vld_q;
  assign rsp_o          = out_rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A miss returns an all-zero word.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !rsp_o.hit) |-> (rsp_o.hit_distance == '0 && rsp_o.hit_point_x == '0
      && rsp_o.hit_point_y == '0 && rsp_o.hit_point_z == '0 && rsp_o.surface_normal_x == '0
      && rsp_o.surface_normal_y == '0 && rsp_o.surface_normal_z == '0))
    else $error("miss word carries nonzero fields");

  // A plane or disc is only ever hit in front of the origin.
  a_plane_t_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.hit && out_plane_q) |-> !rsp_o.hit_distance[W-1])
    else $error("plane or disc hit with negative distance");

  // The three normal lanes run in lockstep.
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nrm_vld[0] == nrm_vld[1]) && (nrm_vld[1] == nrm_vld[2]))
    else $error("normal divider lanes out of step");

  // Every word leaving the length unit reaches the output after the normal unit and the output register.
  a_len_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(u2_vld) |-> ##(rpi_pkg::RES_W + 2) $rose(result_valid_o))
    else $error("word lost between length unit and output");

endmodule

// ===== design/rpi_root_div.sv =====
// Pipelined digit recurrence: one result bit per stage. In square-root mode it returns
// floor(sqrt(operand)); in divide mode it returns operand / divisor, with an overflow
// flag when the quotient does not fit in the result word.
module rpi_root_div #(
  parameter int unsigned SIDE_W = rpi_pkg::DEF_SIDE_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_sqrt_i,
  input  logic [rpi_pkg::OPND_W-1:0] in_opnd_i,
  input  logic [rpi_pkg::RES_W-1:0]  in_dvs_i,
  input  logic [SIDE_W-1:0]          in_side_i,
  output logic                       out_valid_o,
  output logic [rpi_pkg::RES_W-1:0]  out_res_o,
  output logic                       out_ovf_o,
  output logic [SIDE_W-1:0]          out_side_o
);

  localparam int unsigned N  = rpi_pkg::RES_W;
  localparam int unsigned OW = rpi_pkg::OPND_W;
  localparam int unsigned RW = rpi_pkg::REM_W;

  logic          vld_q  [0:N];
  logic          sqrt_q [0:N];
  logic          ovf_q  [0:N];
  logic [RW-1:0] rem_q  [0:N];
  logic [OW-1:0] src_q  [0:N];
  logic [N-1:0]  dvs_q  [0:N];
  logic [N-1:0]  quo_q  [0:N];
  logic [SIDE_W-1:0] side_q [0:N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid_i;
    end
  end

  // The divide mode starts with the upper half as partial remainder; when that half is
  // not below the divisor the quotient overflows.
  always_ff @(posedge clk_i) begin
    sqrt_q[0] <= in_sqrt_i;
    ovf_q[0]  <= !in_sqrt_i && (in_opnd_i[OW-1:N] >= in_dvs_i);
    rem_q[0]  <= in_sqrt_i ? '0 : RW'(in_opnd_i[OW-1:N]);
    src_q[0]  <= in_sqrt_i ? in_opnd_i : {in_opnd_i[N-1:0], {(OW - N){1'b0}}};
    dvs_q[0]  <= in_dvs_i;
    quo_q[0]  <= '0;
    side_q[0] <= in_side_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      if (sqrt_q[k]) begin
        rem_sh = {rem_q[k][RW-3:0], src_q[k][OW-1 -: 2]};
        trial  = {1'b0, quo_q[k], 2'b01};
      end else begin
        rem_sh = {rem_q[k][RW-2:0], src_q[k][OW-1]};
        trial  = RW'(dvs_q[k]);
      end
      ge = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sqrt_q[k+1] <= sqrt_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
      src_q[k+1]  <= sqrt_q[k] ? (src_q[k] << 2) : (src_q[k] << 1);
      dvs_q[k+1]  <= dvs_q[k];
      quo_q[k+1]  <= {quo_q[k][N-2:0], ge};
      side_q[k+1] <= side_q[k];
    end
  end

  assign out_valid_o = vld_q[N];
  assign out_res_o   = quo_q[N];
  assign out_ovf_o   = ovf_q[N];
  assign out_side_o  = side_q[N];

endmodule
